@@ rtl/core/sass_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sass_pkg
// Shared types, constants and microprogram for the animation script stepper.
// ----------------------------------------------------------------------------
package sass_pkg;

    // animation memory geometry
    localparam int MEM_BYTES = 4096;
    localparam int ADDR_W    = $clog2(MEM_BYTES);

    // script constants
    localparam logic [5:0]  NO_SEQUENCE   = 6'd32;
    localparam logic [7:0]  END_FRAME     = 8'd255;
    localparam logic [15:0] HOLD_FOREVER  = 16'd255;
    localparam logic [ADDR_W-1:0] ENTRY_BYTES = ADDR_W'(4);
    localparam logic [9:0]  FT_BASE_BYTE  = 10'd64;   // frame table word 32

    // input opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // payloads
    typedef struct packed {
        logic        opcode;
        logic [11:0] load_address;
        logic [7:0]  load_byte;
        logic [4:0]  sequence_req;
    } t_in;

    typedef struct packed {
        logic               frame_valid;
        logic [7:0]         frame;
        logic signed [15:0] frame_data_offset;
    } t_out;

    // read address source of a step
    typedef enum logic [2:0] {
        A_NONE,
        A_SEQ_LO,
        A_SEQ_HI,
        A_CURSOR,
        A_CURSOR1,
        A_FT_LO,
        A_FT_HI
    } t_asrc;

    // datapath action of a step
    typedef enum logic [3:0] {
        D_NONE,
        D_LO,       // latch low byte of a word
        D_SEQ,      // new sequence: start, cursor, hold
        D_COUNT,    // hold countdown
        D_FRAME,    // latch frame byte
        D_DUR,      // latch duration, maybe rewind to start
        D_ADV,      // cursor advance
        D_EMIT,     // frame result
        D_EMPTY     // no-frame result
    } t_dop;

    // sequencing of a step
    typedef enum logic [2:0] {
        C_WAIT_START,
        C_NEXT,
        C_JUMP,
        C_SEQ_SAME,
        C_HOLD_NZ,
        C_RESTART,
        C_DONE
    } t_cond;

    // step addresses
    localparam int UPC_W = 4;
    localparam logic [UPC_W-1:0] S_IDLE     = 4'd0;
    localparam logic [UPC_W-1:0] S_SEQ_TEST = 4'd1;
    localparam logic [UPC_W-1:0] S_SEQ_HI   = 4'd2;
    localparam logic [UPC_W-1:0] S_SEQ_SET  = 4'd3;
    localparam logic [UPC_W-1:0] S_COUNT    = 4'd4;
    localparam logic [UPC_W-1:0] S_FRAME    = 4'd5;
    localparam logic [UPC_W-1:0] S_DUR      = 4'd6;
    localparam logic [UPC_W-1:0] S_ADV      = 4'd7;
    localparam logic [UPC_W-1:0] S_FT_HI    = 4'd8;
    localparam logic [UPC_W-1:0] S_EMIT     = 4'd9;
    localparam logic [UPC_W-1:0] S_REWIND   = 4'd10;
    localparam logic [UPC_W-1:0] S_EMPTY    = 4'd11;

    typedef struct packed {
        t_asrc             asrc;
        t_dop              dop;
        t_cond             cond;
        logic [UPC_W-1:0]  target;
    } t_uword;

    // control word to the datapath
    typedef struct packed {
        logic  idle;
        t_asrc asrc;
        t_dop  dop;
    } t_ctl;

    // datapath flags to the sequencer
    typedef struct packed {
        logic seq_same;
        logic hold_nz;
        logic restart;
        logic out_free;
    } t_flags;

    // microprogram
    function automatic t_uword ucode(input logic [UPC_W-1:0] upc);
        t_uword w;
        w = '{asrc: A_NONE, dop: D_NONE, cond: C_WAIT_START, target: S_IDLE};
        case (upc)
            S_IDLE:     w = '{A_NONE,    D_NONE,  C_WAIT_START, S_IDLE};
            S_SEQ_TEST: w = '{A_SEQ_LO,  D_NONE,  C_SEQ_SAME,   S_COUNT};
            S_SEQ_HI:   w = '{A_SEQ_HI,  D_LO,    C_NEXT,       S_IDLE};
            S_SEQ_SET:  w = '{A_NONE,    D_SEQ,   C_NEXT,       S_IDLE};
            S_COUNT:    w = '{A_CURSOR,  D_COUNT, C_HOLD_NZ,    S_EMPTY};
            S_FRAME:    w = '{A_CURSOR1, D_FRAME, C_NEXT,       S_IDLE};
            S_DUR:      w = '{A_NONE,    D_DUR,   C_RESTART,    S_REWIND};
            S_REWIND:   w = '{A_CURSOR,  D_NONE,  C_JUMP,       S_FRAME};
            S_ADV:      w = '{A_FT_LO,   D_ADV,   C_NEXT,       S_IDLE};
            S_FT_HI:    w = '{A_FT_HI,   D_LO,    C_NEXT,       S_IDLE};
            S_EMIT:     w = '{A_NONE,    D_EMIT,  C_DONE,       S_IDLE};
            S_EMPTY:    w = '{A_NONE,    D_EMPTY, C_DONE,       S_IDLE};
            default:    w = '{A_NONE,    D_NONE,  C_JUMP,       S_IDLE};
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/sass_useq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sass_useq
// Step counter and microprogram table; issues one control word per cycle.
// ----------------------------------------------------------------------------
module sass_useq
    import sass_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_start,
    input  wire t_flags i_flags,
    output t_ctl        o_ctl
);

    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] n_upc;
    t_uword           w;

    // current control word
    always_comb begin
        w = ucode(r_upc);
        o_ctl.idle = (r_upc == S_IDLE);
        o_ctl.asrc = w.asrc;
        o_ctl.dop  = w.dop;
    end

    // next step
    always_comb begin
        n_upc = r_upc + 4'd1;
        case (w.cond)
            C_WAIT_START: n_upc = i_start ? S_SEQ_TEST : S_IDLE;
            C_NEXT:       n_upc = r_upc + 4'd1;
            C_JUMP:       n_upc = w.target;
            C_SEQ_SAME:   if (i_flags.seq_same) n_upc = w.target;
            C_HOLD_NZ:    if (i_flags.hold_nz) n_upc = w.target;
            C_RESTART:    if (i_flags.restart) n_upc = w.target;
            C_DONE:       n_upc = i_flags.out_free ? S_IDLE : r_upc;
            default:      n_upc = S_IDLE;
        endcase
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= S_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/sprite_animation_script_stepper_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_animation_script_stepper_top
// Animation script stepper: byte memory loader and microcoded tick engine.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (i_in_valid / o_in_ready / i_in) carries load and tick
//   transactions; output channel (o_out_valid / i_out_ready / o_out) returns
//   exactly one result per input transaction, in order.
//   A load writes one byte of the script memory; its all-zero result is
//   registered on acceptance, so it is valid in the next cycle.
//   A tick runs the microprogram, one step per cycle, at most one memory read
//   per step through the single registered read port. A tick without sequence
//   change and with a nonzero hold has the shortest path to its result; a
//   sequence change with an end-marker rewind, the longest. These chains of
//   dependent byte reads set the rate: one item at a time, ready only while
//   the sequencer is idle and the output register is free or being drained.
//   If the receiver stalls, the result waits in the output register and the
//   sequencer holds its final step until the register frees up.
//   Reset (synchronous, active low) selects no sequence, clears cursor,
//   start and hold; memory contents are undefined until loaded, no clearing
//   pass is run.
// ----------------------------------------------------------------------------
module sprite_animation_script_stepper_top
    import sass_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out
);

    t_ctl   ctl;
    t_flags flags;

    logic [7:0]        r_mem [MEM_BYTES];
    logic [7:0]        r_rd_data;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_en;

    logic [5:0]        r_last_seq;
    logic [4:0]        r_seq_req;
    logic [ADDR_W-1:0] r_cursor;
    logic [ADDR_W-1:0] r_start;
    logic [15:0]       r_hold;
    logic [7:0]        r_frame;
    logic [7:0]        r_lo;
    logic              r_wrapped;
    logic              r_out_valid;
    t_out              r_out;

    logic [15:0]       n_hold;
    logic [9:0]        ft_lo;
    logic              in_fire;
    logic              out_free;

    // handshake
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = ctl.idle && out_free;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // countdown value and sequencer flags
    assign n_hold = (r_hold == HOLD_FOREVER) ? r_hold : r_hold - 16'd1;
    assign flags.seq_same = (r_last_seq == {1'b0, r_seq_req});
    assign flags.hold_nz  = (n_hold != 16'd0);
    assign flags.restart  = (r_frame == END_FRAME) && !r_wrapped;
    assign flags.out_free = out_free;

    sass_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_fire && (i_in.opcode == OP_TICK)),
        .i_flags (flags),
        .o_ctl   (ctl)
    );

    // read address select
    assign ft_lo = FT_BASE_BYTE + {1'b0, r_frame, 1'b0};
    always_comb begin
        rd_en   = 1'b1;
        rd_addr = r_cursor;
        case (ctl.asrc)
            A_NONE:    rd_en = 1'b0;
            A_SEQ_LO:  rd_addr = ADDR_W'({r_seq_req, 1'b0});
            A_SEQ_HI:  rd_addr = ADDR_W'({r_seq_req, 1'b1});
            A_CURSOR:  rd_addr = r_cursor;
            A_CURSOR1: rd_addr = r_cursor + ADDR_W'(1);
            A_FT_LO:   rd_addr = ADDR_W'(ft_lo);
            A_FT_HI:   rd_addr = ADDR_W'(ft_lo + 10'd1);
            default:   rd_en = 1'b0;
        endcase
    end

    // script memory: load write port, registered read port
    always_ff @(posedge i_clk) begin
        if (in_fire && (i_in.opcode == OP_LOAD)) begin
            r_mem[ADDR_W'(i_in.load_address)] <= i_in.load_byte;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // payload datapath registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_seq_req <= i_in.sequence_req;
        end
        case (ctl.dop)
            D_LO:    r_lo <= r_rd_data;
            D_FRAME: r_frame <= r_rd_data;
            default: ;
        endcase
    end

    // animation state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_seq <= NO_SEQUENCE;
            r_cursor   <= '0;
            r_start    <= '0;
            r_hold     <= '0;
            r_wrapped  <= 1'b0;
        end else begin
            if (in_fire) begin
                r_wrapped <= 1'b0;
            end
            case (ctl.dop)
                D_SEQ: begin
                    r_last_seq <= {1'b0, r_seq_req};
                    r_start    <= ADDR_W'({r_rd_data, r_lo});
                    r_cursor   <= ADDR_W'({r_rd_data, r_lo});
                    r_hold     <= 16'd1;
                end
                D_COUNT: r_hold <= n_hold;
                D_DUR: begin
                    r_hold <= {8'd0, r_rd_data};
                    if (flags.restart) begin
                        r_cursor  <= r_start;
                        r_wrapped <= 1'b1;
                    end
                end
                D_ADV:   r_cursor <= r_cursor + ENTRY_BYTES;
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire && (i_in.opcode == OP_LOAD)) begin
            r_out_valid <= 1'b1;
        end else if (((ctl.dop == D_EMIT) || (ctl.dop == D_EMPTY)) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && (i_in.opcode == OP_LOAD)) begin
            r_out <= '0;
        end else if ((ctl.dop == D_EMIT) && out_free) begin
            r_out.frame_valid       <= 1'b1;
            r_out.frame             <= r_frame;
            r_out.frame_data_offset <= signed'({r_rd_data, r_lo});
        end else if ((ctl.dop == D_EMPTY) && out_free) begin
            r_out <= '0;
        end
    end

endmodule
`default_nettype wire
